// ===== sv/owfs_pkg.sv =====
`timescale 1ns / 1ps

package owfs_pkg;

  localparam int StackDepth    = 64;
  localparam int MaxFrameBytes = 1024;
  localparam int SlotW         = (StackDepth > 1) ? $clog2(StackDepth) : 1;
  localparam int LenW          = 11;
  localparam int AddrW         = 16;
  localparam int CntW          = 8;
  localparam int ProdW         = SlotW + LenW;

  localparam logic [LenW-1:0]  FrameBytesReset = LenW'(512);
  localparam logic [LenW-1:0]  MaxLen          = LenW'(MaxFrameBytes);
  localparam logic [SlotW-1:0] LastSlot        = SlotW'(StackDepth - 1);
  localparam logic [CntW-1:0]  CntMax          = '1;

  typedef enum logic [1:0] {
    ST_DONE    = 2'd0,
    ST_IGNORED = 2'd1,
    ST_EMPTY   = 2'd2,
    ST_FAIL    = 2'd3
  } status_e;

  typedef enum logic {
    S_IDLE = 1'b0,
    S_EXEC = 1'b1
  } state_e;

  typedef enum logic {
    ACT_PUSH = 1'b0,
    ACT_POP  = 1'b1
  } action_e;

  typedef struct packed {
    status_e          status;
    logic [SlotW-1:0] slot_index;
    logic [AddrW-1:0] byte_address;
    logic [LenW-1:0]  popped_length;
    logic             dropped_oldest;
    logic [SlotW-1:0] occupancy;
    logic [CntW-1:0]  write_errors;
    logic [CntW-1:0]  read_errors;
  } result_t;

endpackage

// ===== sv/overwrite_oldest_frame_stack_unit.sv =====
`timescale 1ns / 1ps

// An accepted word is captured together with the registered read of the length memory
// at the current top slot, executed in S_EXEC, and its result registered at the output.
// No new word is taken in S_EXEC or while a result is held by out_stall_i.
// Reset clears top, bottom, both error counters and the handshake state, and sets the
// frame size to 512; the length memory is not cleared and is valid once written.
module overwrite_oldest_frame_stack_unit (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [owfs_pkg::LenW-1:0]       cfg_wdata_i,
  input  logic                            in_valid_i,
  output logic                            in_stall_o,
  input  logic                            action_i,
  input  logic [owfs_pkg::LenW-1:0]       push_length_i,
  input  logic                            storage_failed_i,
  output logic                            out_valid_o,
  input  logic                            out_stall_i,
  output logic [1:0]                      status_o,
  output logic [owfs_pkg::SlotW-1:0]      slot_index_o,
  output logic [owfs_pkg::AddrW-1:0]      byte_address_o,
  output logic [owfs_pkg::LenW-1:0]       popped_length_o,
  output logic                            dropped_oldest_o,
  output logic [owfs_pkg::SlotW-1:0]      occupancy_o,
  output logic [owfs_pkg::CntW-1:0]       write_errors_o,
  output logic [owfs_pkg::CntW-1:0]       read_errors_o
);

  owfs_pkg::state_e state_q, state_d;

  logic [owfs_pkg::LenW-1:0]  frame_bytes_q;
  logic [owfs_pkg::SlotW-1:0] top_q, top_d;
  logic [owfs_pkg::SlotW-1:0] bottom_q, bottom_d;
  logic [owfs_pkg::CntW-1:0]  wr_err_q, wr_err_d;
  logic [owfs_pkg::CntW-1:0]  rd_err_q, rd_err_d;
  logic                       out_valid_q, out_valid_d;
  owfs_pkg::result_t          result_q, result_d;

  logic                       action_q;
  logic [owfs_pkg::LenW-1:0]  length_q;
  logic                       failed_q;

  logic [owfs_pkg::LenW-1:0]  mem [owfs_pkg::StackDepth];
  logic [owfs_pkg::LenW-1:0]  rd_data_q;
  logic                       wr_en;
  logic [owfs_pkg::SlotW-1:0] wr_addr;
  logic [owfs_pkg::LenW-1:0]  wr_data;

  logic                       accept;
  logic [owfs_pkg::SlotW-1:0] next_slot;
  logic [owfs_pkg::SlotW-1:0] prev_slot;
  logic [owfs_pkg::SlotW-1:0] addr_slot;
  logic [owfs_pkg::ProdW-1:0] product;
  logic                       len_ok;

  assign accept     = in_valid_i && !in_stall_o;
  assign in_stall_o = (state_q == owfs_pkg::S_EXEC) || (out_valid_q && out_stall_i);

  always_ff @(posedge clk_i) begin
    if (accept) begin
      rd_data_q <= mem[top_q];
      action_q  <= action_i;
      length_q  <= push_length_i;
      failed_q  <= storage_failed_i;
    end
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  assign next_slot = (top_q == owfs_pkg::LastSlot) ? '0 : top_q + 1'b1;
  assign prev_slot = (top_q == '0) ? owfs_pkg::LastSlot : top_q - 1'b1;
  assign len_ok    = (length_q != '0) && (length_q <= frame_bytes_q) &&
                     (length_q <= owfs_pkg::MaxLen);
  assign addr_slot = (action_q == owfs_pkg::ACT_PUSH) ? next_slot : top_q;
  assign product   = owfs_pkg::ProdW'(addr_slot) * owfs_pkg::ProdW'(frame_bytes_q);

  always_comb begin
    state_d     = state_q;
    top_d       = top_q;
    bottom_d    = bottom_q;
    wr_err_d    = wr_err_q;
    rd_err_d    = rd_err_q;
    result_d    = result_q;
    out_valid_d = out_valid_q && out_stall_i;
    wr_en       = 1'b0;
    wr_addr     = top_q;
    wr_data     = length_q;

    unique case (state_q)
      owfs_pkg::S_IDLE: begin
        if (accept) begin
          state_d = owfs_pkg::S_EXEC;
        end
      end
      owfs_pkg::S_EXEC: begin
        state_d                 = owfs_pkg::S_IDLE;
        out_valid_d             = 1'b1;
        result_d.status         = owfs_pkg::ST_DONE;
        result_d.slot_index     = '0;
        result_d.byte_address   = '0;
        result_d.popped_length  = '0;
        result_d.dropped_oldest = 1'b0;
        if (action_q == owfs_pkg::ACT_PUSH) begin
          if (!len_ok) begin
            result_d.status = owfs_pkg::ST_IGNORED;
          end else begin
            result_d.slot_index   = next_slot;
            result_d.byte_address = product[owfs_pkg::AddrW-1:0];
            if (failed_q) begin
              result_d.status = owfs_pkg::ST_FAIL;
              wr_err_d = (wr_err_q == owfs_pkg::CntMax) ? wr_err_q : wr_err_q + 1'b1;
            end else begin
              wr_err_d = '0;
              if (next_slot == bottom_q) begin
                bottom_d = (bottom_q == owfs_pkg::LastSlot) ? '0 : bottom_q + 1'b1;
                result_d.dropped_oldest = 1'b1;
              end
              top_d   = next_slot;
              wr_en   = 1'b1;
              wr_addr = next_slot;
              wr_data = length_q;
            end
          end
        end else begin
          if (top_q == bottom_q) begin
            result_d.status = owfs_pkg::ST_EMPTY;
          end else begin
            result_d.slot_index   = top_q;
            result_d.byte_address = product[owfs_pkg::AddrW-1:0];
            if (rd_data_q != '0) begin
              if (failed_q) begin
                result_d.status = owfs_pkg::ST_FAIL;
                rd_err_d = (rd_err_q == owfs_pkg::CntMax) ? rd_err_q : rd_err_q + 1'b1;
              end else begin
                result_d.popped_length = rd_data_q;
                rd_err_d = '0;
              end
            end
            wr_en   = 1'b1;
            wr_addr = top_q;
            wr_data = '0;
            top_d   = prev_slot;
          end
        end
        result_d.occupancy    = (top_d >= bottom_d) ? top_d - bottom_d :
                                owfs_pkg::SlotW'(owfs_pkg::StackDepth) + top_d - bottom_d;
        result_d.write_errors = wr_err_d;
        result_d.read_errors  = rd_err_d;
      end
      default: begin
        state_d = owfs_pkg::S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= owfs_pkg::S_IDLE;
      frame_bytes_q <= owfs_pkg::FrameBytesReset;
      top_q         <= '0;
      bottom_q      <= '0;
      wr_err_q      <= '0;
      rd_err_q      <= '0;
      out_valid_q   <= 1'b0;
    end else begin
      state_q     <= state_d;
      top_q       <= top_d;
      bottom_q    <= bottom_d;
      wr_err_q    <= wr_err_d;
      rd_err_q    <= rd_err_d;
      out_valid_q <= out_valid_d;
      if (cfg_we_i) begin
        frame_bytes_q <= cfg_wdata_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    result_q <= result_d;
  end

  assign out_valid_o      = out_valid_q;
  assign status_o         = result_q.status;
  assign slot_index_o     = result_q.slot_index;
  assign byte_address_o   = result_q.byte_address;
  assign popped_length_o  = result_q.popped_length;
  assign dropped_oldest_o = result_q.dropped_oldest;
  assign occupancy_o      = result_q.occupancy;
  assign write_errors_o   = result_q.write_errors;
  assign read_errors_o    = result_q.read_errors;

  a_accept_to_exec: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> state_q == owfs_pkg::S_EXEC)
    else $error("accepted word did not enter execution");

  a_exec_gives_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == owfs_pkg::S_EXEC |=> out_valid_o)
    else $error("execution did not present a result");

  a_empty_occupancy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && status_o == owfs_pkg::ST_EMPTY |-> occupancy_o == '0)
    else $error("empty status with nonzero occupancy");

  a_drop_means_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && dropped_oldest_o |-> occupancy_o == owfs_pkg::LastSlot)
    else $error("oldest frame dropped while stack not full");

endmodule

// ===== verif/tb_overwrite_oldest_frame_stack_unit.sv =====
`timescale 1ns / 1ps

module tb_overwrite_oldest_frame_stack_unit;

  typedef struct {
    bit                        is_cfg;
    logic [owfs_pkg::LenW-1:0] cfg_value;
    bit                        drain;
    owfs_pkg::action_e         action;
    logic [owfs_pkg::LenW-1:0] push_length;
    logic                      storage_failed;
    int                        phase;
  } stim_t;

  logic                       clk_i             = 1'b0;
  logic                       rst_ni            = 1'b0;
  logic                       cfg_we            = 1'b0;
  logic [owfs_pkg::LenW-1:0]  cfg_wdata         = '0;
  logic                       in_valid          = 1'b0;
  logic                       in_stall;
  owfs_pkg::action_e          in_action         = owfs_pkg::ACT_PUSH;
  logic [owfs_pkg::LenW-1:0]  in_push_length    = '0;
  logic                       in_storage_failed = 1'b0;
  logic                       out_valid;
  logic                       out_stall         = 1'b0;
  logic [1:0]                 out_status;
  logic [owfs_pkg::SlotW-1:0] out_slot_index;
  logic [owfs_pkg::AddrW-1:0] out_byte_address;
  logic [owfs_pkg::LenW-1:0]  out_popped_length;
  logic                       out_dropped_oldest;
  logic [owfs_pkg::SlotW-1:0] out_occupancy;
  logic [owfs_pkg::CntW-1:0]  out_write_errors;
  logic [owfs_pkg::CntW-1:0]  out_read_errors;

  stim_t             pending_words[$];
  owfs_pkg::result_t expected_results[$];
  int      words_issued  = 0;
  int      words_retired = 0;
  int      mismatches    = 0;
  int      rx_phase      = 0;
  int      gen_phase     = 0;

  logic [owfs_pkg::SlotW-1:0] top_slot    = '0;
  logic [owfs_pkg::SlotW-1:0] bottom_slot = '0;
  logic [owfs_pkg::LenW-1:0]  slot_length [owfs_pkg::StackDepth];
  logic [owfs_pkg::CntW-1:0]  write_errs  = '0;
  logic [owfs_pkg::CntW-1:0]  read_errs   = '0;
  logic [owfs_pkg::LenW-1:0]  frame_bytes = owfs_pkg::FrameBytesReset;
  logic [owfs_pkg::LenW-1:0]  gen_frame   = owfs_pkg::FrameBytesReset;

  overwrite_oldest_frame_stack_unit dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_we_i         (cfg_we),
    .cfg_wdata_i      (cfg_wdata),
    .in_valid_i       (in_valid),
    .in_stall_o       (in_stall),
    .action_i         (in_action),
    .push_length_i    (in_push_length),
    .storage_failed_i (in_storage_failed),
    .out_valid_o      (out_valid),
    .out_stall_i      (out_stall),
    .status_o         (out_status),
    .slot_index_o     (out_slot_index),
    .byte_address_o   (out_byte_address),
    .popped_length_o  (out_popped_length),
    .dropped_oldest_o (out_dropped_oldest),
    .occupancy_o      (out_occupancy),
    .write_errors_o   (out_write_errors),
    .read_errors_o    (out_read_errors)
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  function automatic int sender_idle(input int phase);
    case (phase)
      0: return 11;
      1: return 61;
      default: return 0;
    endcase
  endfunction

  function automatic int receiver_idle(input int phase);
    case (phase)
      0: return 61;
      1: return 11;
      default: return 0;
    endcase
  endfunction

  task automatic predict_stack(input owfs_pkg::action_e act,
                               input logic [owfs_pkg::LenW-1:0] len,
                               input logic failed, output owfs_pkg::result_t r);
    logic [owfs_pkg::SlotW-1:0] pos;
    logic [owfs_pkg::ProdW-1:0] prod;
    r = '0;
    if (act == owfs_pkg::ACT_PUSH) begin
      if (len == '0 || len > frame_bytes || len > owfs_pkg::MaxLen) begin
        r.status = owfs_pkg::ST_IGNORED;
      end else begin
        pos            = top_slot + 1'b1;
        prod           = owfs_pkg::ProdW'(pos) * owfs_pkg::ProdW'(frame_bytes);
        r.slot_index   = pos;
        r.byte_address = prod[owfs_pkg::AddrW-1:0];
        if (failed) begin
          r.status = owfs_pkg::ST_FAIL;
          if (write_errs != owfs_pkg::CntMax) write_errs = write_errs + 1'b1;
        end else begin
          r.status   = owfs_pkg::ST_DONE;
          write_errs = '0;
          if (pos == bottom_slot) begin
            bottom_slot      = bottom_slot + 1'b1;
            r.dropped_oldest = 1'b1;
          end
          top_slot         = pos;
          slot_length[pos] = len;
        end
      end
    end else if (top_slot == bottom_slot) begin
      r.status = owfs_pkg::ST_EMPTY;
    end else begin
      prod           = owfs_pkg::ProdW'(top_slot) * owfs_pkg::ProdW'(frame_bytes);
      r.slot_index   = top_slot;
      r.byte_address = prod[owfs_pkg::AddrW-1:0];
      r.status       = owfs_pkg::ST_DONE;
      // A zero stored length means no storage access, so the failure flag is moot.
      if (slot_length[top_slot] != '0) begin
        if (failed) begin
          r.status = owfs_pkg::ST_FAIL;
          if (read_errs != owfs_pkg::CntMax) read_errs = read_errs + 1'b1;
        end else begin
          r.popped_length = slot_length[top_slot];
          read_errs       = '0;
        end
      end
      slot_length[top_slot] = '0;
      top_slot              = top_slot - 1'b1;
    end
    r.occupancy    = top_slot - bottom_slot;
    r.write_errors = write_errs;
    r.read_errors  = read_errs;
  endtask

  task automatic show_result(input string tag, input owfs_pkg::result_t r);
    $display("  %s: status=%0d slot=%0d addr=%0d len=%0d drop=%0d occ=%0d werr=%0d rerr=%0d",
             tag, r.status, r.slot_index, r.byte_address, r.popped_length,
             r.dropped_oldest, r.occupancy, r.write_errors, r.read_errors);
  endtask

  task automatic add_item(input owfs_pkg::action_e a, input int len, input bit failed,
                          input bit drain);
    stim_t s;
    s.is_cfg         = 1'b0;
    s.cfg_value      = '0;
    s.drain          = drain;
    s.action         = a;
    s.push_length    = owfs_pkg::LenW'(len);
    s.storage_failed = failed;
    s.phase          = gen_phase;
    pending_words.push_back(s);
  endtask

  task automatic add_cfg(input int value);
    stim_t s;
    s.is_cfg         = 1'b1;
    s.cfg_value      = owfs_pkg::LenW'(value);
    s.drain          = 1'b1;
    s.action         = owfs_pkg::ACT_PUSH;
    s.push_length    = '0;
    s.storage_failed = 1'b0;
    s.phase          = gen_phase;
    pending_words.push_back(s);
    gen_frame = owfs_pkg::LenW'(value);
  endtask

  // Bursts of pushes and pops keep the stack wrapping and draining.
  task automatic add_mix(input int count);
    int made;
    int run;
    int kind;
    int len;
    made = 0;
    while (made < count) begin
      kind = $urandom_range(9);
      run  = (kind < 5) ? $urandom_range(80, 1) : $urandom_range(70, 1);
      for (int k = 0; k < run; k++) begin
        if (kind < 5) begin
          if ($urandom_range(99) < 92) begin
            len = $urandom_range(gen_frame, 1);
          end else if ($urandom_range(1) == 0 || gen_frame >= owfs_pkg::MaxFrameBytes) begin
            len = 0;
          end else begin
            len = $urandom_range(owfs_pkg::MaxFrameBytes, gen_frame + 1);
          end
          add_item(owfs_pkg::ACT_PUSH, len, $urandom_range(99) < 8,
                   $urandom_range(99) == 0);
        end else if (kind < 9) begin
          add_item(owfs_pkg::ACT_POP, $urandom_range(owfs_pkg::MaxFrameBytes),
                   $urandom_range(99) < 10, $urandom_range(99) == 0);
        end else begin
          add_item(owfs_pkg::action_e'($urandom_range(1)),
                   $urandom_range(owfs_pkg::MaxFrameBytes),
                   1'($urandom_range(1)), 1'b0);
        end
      end
      made += run;
    end
  endtask

  always @(posedge clk_i) begin : driver
    stim_t             nxt;
    owfs_pkg::result_t res;
    logic              nv;
    if (rst_ni) begin
      if (cfg_we) begin
        cfg_we <= 1'b0;
      end else if (!(in_valid && in_stall)) begin
        if (in_valid) begin
          predict_stack(in_action, in_push_length, in_storage_failed, res);
          expected_results.push_back(res);
          words_issued++;
        end
        nv = 1'b0;
        if (pending_words.size() > 0) begin
          nxt = pending_words[0];
          rx_phase <= nxt.phase;
          if (nxt.is_cfg) begin
            if (!in_valid && words_issued == words_retired) begin
              cfg_we      <= 1'b1;
              cfg_wdata   <= nxt.cfg_value;
              frame_bytes  = nxt.cfg_value;
              void'(pending_words.pop_front());
            end
          end else if (!(nxt.drain && words_issued != words_retired) &&
                       $urandom_range(99) >= sender_idle(nxt.phase)) begin
            nv = 1'b1;
            in_action         <= nxt.action;
            in_push_length    <= nxt.push_length;
            in_storage_failed <= nxt.storage_failed;
            void'(pending_words.pop_front());
          end
        end
        in_valid <= nv;
      end
    end
  end

  always @(posedge clk_i) begin : monitor
    owfs_pkg::result_t got;
    owfs_pkg::result_t want;
    if (rst_ni) begin
      if (out_valid && !out_stall) begin
        got.status         = owfs_pkg::status_e'(out_status);
        got.slot_index     = out_slot_index;
        got.byte_address   = out_byte_address;
        got.popped_length  = out_popped_length;
        got.dropped_oldest = out_dropped_oldest;
        got.occupancy      = out_occupancy;
        got.write_errors   = out_write_errors;
        got.read_errors    = out_read_errors;
        if (expected_results.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) begin
            $display("mismatch at %0t: word with nothing expected", $realtime);
            show_result("actual", got);
          end
        end else begin
          want = expected_results.pop_front();
          words_retired <= words_retired + 1;
          if (got !== want) begin
            mismatches++;
            if (mismatches <= 10) begin
              $display("mismatch at %0t:", $realtime);
              show_result("expected", want);
              show_result("actual", got);
            end
          end
        end
      end
      out_stall <= ($urandom_range(99) < receiver_idle(rx_phase));
    end
  end

  initial begin : sequencer
    gen_phase = 0;
    add_item(owfs_pkg::ACT_POP, 0, 1'b0, 1'b0);
    add_item(owfs_pkg::ACT_POP, 1024, 1'b1, 1'b0);
    add_item(owfs_pkg::ACT_PUSH, 0, 1'b0, 1'b0);
    add_item(owfs_pkg::ACT_PUSH, 513, 1'b0, 1'b0);
    add_item(owfs_pkg::ACT_PUSH, 1024, 1'b0, 1'b0);
    add_item(owfs_pkg::ACT_PUSH, 512, 1'b0, 1'b0);
    add_item(owfs_pkg::ACT_PUSH, 1, 1'b0, 1'b0);
    add_item(owfs_pkg::ACT_PUSH, 300, 1'b1, 1'b0);
    add_item(owfs_pkg::ACT_PUSH, 300, 1'b1, 1'b0);
    add_item(owfs_pkg::ACT_PUSH, 7, 1'b0, 1'b0);
    add_item(owfs_pkg::ACT_POP, 0, 1'b0, 1'b0);
    add_item(owfs_pkg::ACT_POP, 0, 1'b1, 1'b0);
    add_item(owfs_pkg::ACT_POP, 0, 1'b0, 1'b0);
    add_item(owfs_pkg::ACT_POP, 0, 1'b1, 1'b0);
    add_cfg(1024);
    add_item(owfs_pkg::ACT_PUSH, 1024, 1'b0, 1'b0);
    add_item(owfs_pkg::ACT_POP, 0, 1'b0, 1'b0);
    add_cfg(1);
    add_item(owfs_pkg::ACT_PUSH, 1, 1'b0, 1'b0);
    add_item(owfs_pkg::ACT_PUSH, 2, 1'b0, 1'b0);
    add_item(owfs_pkg::ACT_POP, 2047, 1'b0, 1'b0);
    add_cfg($urandom_range(1023, 2));
    add_mix(300);

    gen_phase = 1;
    add_cfg(1024);
    for (int k = 0; k < 262; k++) begin
      add_item(owfs_pkg::ACT_PUSH, $urandom_range(1024, 1), 1'b1, k == 0);
    end
    for (int r = 0; r < 5; r++) begin
      for (int k = 0; k < 66; k++) begin
        add_item(owfs_pkg::ACT_PUSH, $urandom_range(1024, 1), 1'b0, 1'b0);
      end
      for (int k = 0; k < 66; k++) begin
        add_item(owfs_pkg::ACT_POP, 0, 1'b1, 1'b0);
      end
    end
    add_mix(100);

    gen_phase = 2;
    add_cfg(1);
    add_mix(100);
    add_cfg($urandom_range(1024, 1));
    add_mix(150);

    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    while (pending_words.size() != 0 || in_valid || cfg_we || words_issued != words_retired)
      @(posedge clk_i);
    repeat (8) @(posedge clk_i);
    if (mismatches == 0 && expected_results.size() == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

  initial begin : watchdog
    #2_000_000;
    $display("end of test: mismatches");
    $finish;
  end

endmodule

// ===== files.f =====
sv/owfs_pkg.sv
sv/overwrite_oldest_frame_stack_unit.sv
verif/tb_overwrite_oldest_frame_stack_unit.sv
